// ----- rtl/hkc_pkg.sv -----
// Shared types, constants and helper functions for the keyframe curve evaluator.
// No dependencies; the core, the checker and the testbench refer to this package.
`timescale 1ns / 1ps
`default_nettype none
package hkc_pkg;

  localparam int MAX_KEYS_DEF = 64;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int  CFG_IDX_W     = 1;
  localparam int  CFG_DATA_W    = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_TAN   = 1'd1;

  localparam logic [33:0] ONE_Q30  = 34'h0_4000_0000;
  localparam logic [67:0] ROUND_HALF = 68'd15 << 22;
  localparam logic [51:0] Y_BIAS   = 52'd30 << 45;
  localparam logic [51:0] Q_BIAS   = 52'd1 << 45;

  typedef struct packed {
    logic signed [15:0] ktime;
    logic signed [15:0] value;
    logic signed [15:0] tin;
    logic signed [15:0] tout;
  } key_t;

  // Quotient digit of a 9-bit value by 30 (value stays below 480).
  function automatic logic [3:0] div30(input logic [8:0] t);
    logic [3:0] qd;
    qd = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (t >= 9'(30 * k)) qd = 4'(k);
    end
    return qd;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hkc_if.sv -----
// Handshake channel interfaces: request items in, curve results out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface hkc_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [5:0]         key_index;
  logic signed [15:0] key_time;
  logic signed [15:0] key_value;
  logic signed [15:0] key_in_tangent;
  logic signed [15:0] key_out_tangent;
  logic signed [15:0] query_time;
  modport source (output valid, func, key_index, key_time, key_value, key_in_tangent,
                  key_out_tangent, query_time, input ready);
  modport sink   (input valid, func, key_index, key_time, key_value, key_in_tangent,
                  key_out_tangent, query_time, output ready);
endinterface

interface hkc_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] curve_value;
  logic               saturated;
  modport source (output valid, curve_value, saturated, input ready);
  modport sink   (input valid, curve_value, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/hkc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hkc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/hermite_keyframe_curve.sv -----
// Keyframe table with cubic Hermite evaluation; uses hkc_pkg, hkc_if, hkc_ram.
// A key write goes straight to the result stage. A query outside the keys takes its
// result from the first or last key; a query inside a segment passes through
// the walk over the key table (one read a cycle), a 30-step divider for the segment
// fraction, 11 multiply steps and a 13-step radix-16 divide by 30.
// One item is in work at a time; the next is accepted once the result is in the output
// register. Reset clears control state, key_count to 1 and separate_tangents to 0;
// the key table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module hermite_keyframe_curve #(
  parameter int MAX_KEYS = hkc_pkg::MAX_KEYS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  hkc_req_if.sink                               req,
  hkc_rsp_if.source                             rsp,
  input  wire logic                             cfg_we,
  input  wire logic [hkc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hkc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int AW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_K0   = 3'd1;
  localparam logic [2:0] S_KL   = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_SDIV = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_QDIV = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]  state;
  logic [4:0]  cnt;
  logic [6:0]  key_count;
  logic        sep_tan;

  logic [NW-1:0] nkeys;
  logic [AW-1:0] idx;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  hkc_pkg::key_t rd_key;
  logic [63:0]   rd_data;

  logic signed [15:0] q;
  hkc_pkg::key_t      k0;
  hkc_pkg::key_t      k1;
  logic [16:0] dreg, hreg, rem;
  logic [29:0] s;
  logic [30:0] s2, s3, u2, w, u;
  logic [32:0] b01;
  logic signed [33:0] b00;
  logic signed [49:0] p0, p1;
  logic signed [48:0] pa, pb;
  logic signed [15:0] m0;
  logic signed [67:0] tt, tx;
  logic [51:0] y, quo, quo_next;
  logic signed [51:0] rs;
  logic [4:0]  r30;
  logic [8:0]  t9;
  logic [3:0]  qd;
  logic [17:0] r2;
  logic signed [17:0] d_s, h_s;
  logic        seg_stop;
  logic [31:0] res_value;
  logic        res_sat;

  logic        req_fire;
  assign req_fire = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rd_key = hkc_pkg::key_t'(rd_data);

  // Clamp the key count into 1..MAX_KEYS.
  always_comb begin
    if (key_count == 7'd0) nkeys = NW'(1);
    else if (32'(key_count) > 32'(MAX_KEYS)) nkeys = NW'(MAX_KEYS);
    else nkeys = NW'(key_count);
  end

  assign seg_stop = (q < rd_key.ktime) || ((NW + 1)'(idx) + (NW + 1)'(2) >= (NW + 1)'(nkeys));
  assign d_s = 18'(q) - 18'(k0.ktime);
  assign h_s = 18'(rd_key.ktime) - 18'(k0.ktime);
  assign u   = 31'(hkc_pkg::ONE_Q30) - {1'b0, s};
  assign b00 = $signed(hkc_pkg::ONE_Q30) - $signed({1'b0, b01});
  assign m0  = sep_tan ? k0.tout : k0.tin;
  assign r2  = {rem, 1'b0};
  assign tx  = (tt + $signed(hkc_pkg::ROUND_HALF)) >>> 22;
  assign t9  = {r30, y[51:48]};
  assign qd  = hkc_pkg::div30(t9);
  assign quo_next = {quo[47:0], qd};
  assign rs  = $signed(quo_next - hkc_pkg::Q_BIAS);

  always_comb begin
    case (state)
      S_K0:    rd_addr = AW'(nkeys - NW'(1));
      S_KL:    rd_addr = AW'(1);
      S_SRCH:  rd_addr = idx + AW'(2);
      default: rd_addr = '0;
    endcase
  end

  assign wr_en = req_fire && (req.func == hkc_pkg::FUNC_WRITE) &&
                 (32'(req.key_index) < 32'(MAX_KEYS));

  hkc_ram #(.WIDTH(64), .DEPTH(MAX_KEYS)) u_key_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(req.key_index)),
    .wdata ({req.key_time, req.key_value, req.key_in_tangent, req.key_out_tangent}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= 7'd1;
      sep_tan   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        hkc_pkg::CFG_KEY_COUNT: key_count <= cfg_data;
        hkc_pkg::CFG_SEP_TAN:   sep_tan   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            q <= req.query_time;
            if (req.func == hkc_pkg::FUNC_WRITE) begin
              res_value <= '0;
              res_sat   <= 1'b0;
              state     <= S_DONE;
            end else begin
              state <= S_K0;
            end
          end
        end
        S_K0: begin
          k0 <= rd_key;
          if (q <= rd_key.ktime) begin
            res_value <= {{8{rd_key.value[15]}}, rd_key.value, 8'h00};
            res_sat   <= 1'b0;
            state     <= S_DONE;
          end else begin
            state <= S_KL;
          end
        end
        S_KL: begin
          idx <= '0;
          if (q >= rd_key.ktime) begin
            res_value <= {{8{rd_key.value[15]}}, rd_key.value, 8'h00};
            res_sat   <= 1'b0;
            state     <= S_DONE;
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (seg_stop) begin
            k1 <= rd_key;
            if (h_s <= 18'sd0 || d_s < 18'sd0 || d_s >= h_s) begin
              res_value <= {{8{k0.value[15]}}, k0.value, 8'h00};
              res_sat   <= 1'b0;
              state     <= S_DONE;
            end else begin
              dreg  <= d_s[16:0];
              hreg  <= h_s[16:0];
              rem   <= d_s[16:0];
              cnt   <= '0;
              state <= S_SDIV;
            end
          end else begin
            // advance to the next segment
            k0  <= rd_key;
            idx <= idx + AW'(1);
          end
        end
        S_SDIV: begin
          if (r2 >= {1'b0, hreg}) begin
            rem <= 17'(r2 - {1'b0, hreg});
            s   <= {s[28:0], 1'b1};
          end else begin
            rem <= r2[16:0];
            s   <= {s[28:0], 1'b0};
          end
          if (cnt == 5'd29) begin
            cnt   <= '0;
            state <= S_MUL;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_MUL: begin
          if (cnt != 5'd10) cnt <= cnt + 5'd1;
          case (cnt)
            5'd0: s2 <= 31'((60'(s) * 60'(s)) >> 30);
            5'd1: s3 <= 31'((61'(s2) * 61'(s)) >> 30);
            5'd2: u2 <= 31'((62'(u) * 62'(u)) >> 30);
            5'd3: begin
              w   <= 31'((61'(s) * 61'(u)) >> 30);
              b01 <= 33'(s2) * 33'd3 - 33'(s3) * 33'd2;
            end
            5'd4: p0 <= 50'(k0.value) * 50'(b00);
            5'd5: p1 <= 50'(k1.value) * 50'($signed({1'b0, b01}));
            5'd6: pa <= 49'(m0) * 49'($signed({1'b0, u2}));
            5'd7: pb <= 49'(k1.tin) * 49'($signed({1'b0, w}));
            5'd8: begin
              p0 <= p0 + p1;
              pa <= pa - pb;
            end
            5'd9: tt <= 68'(p0) * 68'sd30 + 68'($signed({1'b0, dreg})) * 68'(pa);
            default: begin
              // bias to a positive dividend for the divide by 30
              y     <= 52'(tx) + hkc_pkg::Y_BIAS;
              r30   <= '0;
              quo   <= '0;
              cnt   <= '0;
              state <= S_QDIV;
            end
          endcase
        end
        S_QDIV: begin
          r30 <= 5'(t9 - 9'(qd) * 9'd30);
          y   <= {y[47:0], 4'h0};
          quo <= quo_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd12) begin
            if (rs > 52'sh0_0000_7FFF_FFFF) begin
              res_value <= 32'h7FFF_FFFF;
              res_sat   <= 1'b1;
            end else if (rs < -52'sh0_0000_8000_0000) begin
              res_value <= 32'h8000_0000;
              res_sat   <= 1'b1;
            end else begin
              res_value <= rs[31:0];
              res_sat   <= 1'b0;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.curve_value <= res_value;
            rsp.saturated   <= res_sat;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/hkc_chk.sv -----
// Port-level checker for hermite_keyframe_curve, bound to the top level.
// Depends on hkc_pkg for function codes.
`timescale 1ns / 1ps
`default_nettype none
module hkc_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        req_func,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] curve_value,
  input wire logic        saturated
);
  logic req_fire;
  assign req_fire = req_valid && req_ready;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(curve_value) && $stable(saturated))
    else $error("result dropped or changed while stalled");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && saturated |-> curve_value == 32'h7FFF_FFFF || curve_value == 32'h8000_0000)
    else $error("saturated flag without a clipped value");

  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    req_fire && req_func == hkc_pkg::FUNC_WRITE && !rsp_valid
    |-> ##2 rsp_valid && curve_value == 32'd0 && !saturated)
    else $error("key write transaction gave no zero result");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("second transaction taken while an item is in work");
endmodule

bind hermite_keyframe_curve hkc_chk u_hkc_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_func    (req.func),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .curve_value (rsp.curve_value),
  .saturated   (rsp.saturated)
);
`default_nettype wire

// ----- sim/tb_hermite_keyframe_curve.sv -----
// Self-checking testbench for hermite_keyframe_curve: key writes and curve queries.
// Depends on hkc_pkg, hkc_if and the RTL; predicts each result in fixed point.
`timescale 1ns / 1ps
module tb_hermite_keyframe_curve;

  localparam int  NKEYS    = 64;
  localparam int  LIMIT    = 1_000_000;
  localparam int  N_PHASES = 12;
  localparam int  LONG_HOLD = 600;

  typedef struct {
    logic               func;
    logic [5:0]         slot;
    logic signed [15:0] ktime;
    logic signed [15:0] kval;
    logic signed [15:0] kin;
    logic signed [15:0] kout;
    logic signed [15:0] qtime;
  } curve_req_t;

  typedef struct {
    logic signed [31:0] value;
    logic               sat;
  } curve_rsp_t;

  logic clk;
  logic rst;
  logic                           cfg_we;
  logic [hkc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hkc_pkg::CFG_DATA_W-1:0] cfg_data;

  hkc_req_if req_ch();
  hkc_rsp_if rsp_ch();

  hermite_keyframe_curve u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch.sink),
    .rsp       (rsp_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Mirror of the key table and registers
  hkc_pkg::key_t key_mirror [NKEYS];
  logic [6:0] count_reg;
  logic       sep_reg;

  curve_req_t pending_q[$];
  curve_rsp_t curve_expect_q[$];

  int  errors = 0;
  int  n_writes = 0;
  int  n_queries = 0;
  int  n_sat = 0;
  int  n_checked = 0;
  int  cycles = 0;
  bit  calm;
  int  hold_req;
  int  hold_seen;
  int  hold_left;
  int  send_gap;
  int  recv_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint floor_div(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // Hermite blend inside segment i..i+1, Q23.8 before saturation
  function automatic longint hermite_segment(int i, longint q);
    longint one, d, h, s, s2, s3, b01, b00, u, u2, w, m0, m1, acc, v0, v1;
    one = longint'(1) << 30;
    v0  = key_mirror[i].value;
    v1  = key_mirror[i+1].value;
    d   = q - longint'(key_mirror[i].ktime);
    h   = longint'(key_mirror[i+1].ktime) - longint'(key_mirror[i].ktime);
    if (h <= 0 || d < 0 || d >= h) return v0 * 256;
    s   = (d <<< 30) / h;
    s2  = (s * s) >>> 30;
    s3  = (s2 * s) >>> 30;
    b01 = 3 * s2 - 2 * s3;
    b00 = one - b01;
    u   = one - s;
    u2  = (u * u) >>> 30;
    w   = (s * u) >>> 30;
    m0  = sep_reg ? longint'(key_mirror[i].tout) : longint'(key_mirror[i].tin);
    m1  = key_mirror[i+1].tin;
    acc = 30 * (v0 * b00 + v1 * b01) + d * (m0 * u2 - m1 * w);
    return floor_div(acc + 15 * (longint'(1) << 22), 30 * (longint'(1) << 22));
  endfunction

  function automatic curve_rsp_t eval_curve(curve_req_t it);
    curve_rsp_t r;
    longint val, q;
    int n, i;
    r.value = '0;
    r.sat   = 1'b0;
    if (it.func == hkc_pkg::FUNC_WRITE) begin
      key_mirror[it.slot] = '{ktime: it.ktime, value: it.kval, tin: it.kin, tout: it.kout};
      return r;
    end
    n = count_reg;
    if (n == 0) n = 1;
    if (n > NKEYS) n = NKEYS;
    q = it.qtime;
    if (q <= key_mirror[0].ktime) begin
      val = longint'(key_mirror[0].value) * 256;
    end else if (q >= key_mirror[n-1].ktime) begin
      val = longint'(key_mirror[n-1].value) * 256;
    end else begin
      i = 0;
      while (i + 2 < n && !(q < key_mirror[i+1].ktime)) i++;
      val = hermite_segment(i, q);
    end
    if (val > 64'sd2147483647) begin
      val = 64'sd2147483647;
      r.sat = 1'b1;
    end else if (val < -64'sd2147483648) begin
      val = -64'sd2147483648;
      r.sat = 1'b1;
    end
    r.value = val[31:0];
    return r;
  endfunction

  // Driver: present the queue head, hold until accepted, then idle a while
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        curve_expect_q.push_back(eval_curve(pending_q[0]));
        if (pending_q[0].func == hkc_pkg::FUNC_WRITE) n_writes++;
        else n_queries++;
        void'(pending_q.pop_front());
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered transaction
      end else if (send_gap > 0) begin
        send_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req_ch.valid           <= 1'b1;
        req_ch.func            <= pending_q[0].func;
        req_ch.key_index       <= pending_q[0].slot;
        req_ch.key_time        <= pending_q[0].ktime;
        req_ch.key_value       <= pending_q[0].kval;
        req_ch.key_in_tangent  <= pending_q[0].kin;
        req_ch.key_out_tangent <= pending_q[0].kout;
        req_ch.query_time      <= pending_q[0].qtime;
        send_gap = calm ? 0 : pick_gap();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result transaction, stall ready at random
  always @(posedge clk) begin
    curve_rsp_t e;
    logic rdy_n;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
      recv_gap = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (curve_expect_q.size() == 0) begin
          errors++;
          $display("%0t ERROR unexpected result: curve_value %0d saturated %0b",
                   $time, rsp_ch.curve_value, rsp_ch.saturated);
        end else begin
          e = curve_expect_q.pop_front();
          n_checked++;
          if (rsp_ch.saturated) n_sat++;
          if (rsp_ch.curve_value !== e.value) begin
            errors++;
            $display("%0t ERROR curve_value expected %0d actual %0d",
                     $time, e.value, rsp_ch.curve_value);
          end
          if (rsp_ch.saturated !== e.sat) begin
            errors++;
            $display("%0t ERROR saturated expected %0b actual %0b",
                     $time, e.sat, rsp_ch.saturated);
          end
        end
        recv_gap = calm ? 0 : pick_gap();
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy_n = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy_n = 1'b0;
      end else begin
        rdy_n = 1'b1;
      end
      rsp_ch.ready <= rdy_n;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, curve_expect_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic curve_req_t key_write(int slot, int t, int v, int ti, int to);
    curve_req_t it;
    it.func  = hkc_pkg::FUNC_WRITE;
    it.slot  = 6'(slot);
    it.ktime = 16'(t);
    it.kval  = 16'(v);
    it.kin   = 16'(ti);
    it.kout  = 16'(to);
    it.qtime = 16'($urandom);
    return it;
  endfunction

  function automatic curve_req_t query_at(int t);
    curve_req_t it;
    it.func  = hkc_pkg::FUNC_QUERY;
    it.slot  = 6'($urandom);
    it.ktime = 16'($urandom);
    it.kval  = 16'($urandom);
    it.kin   = 16'($urandom);
    it.kout  = 16'($urandom);
    it.qtime = 16'(t);
    return it;
  endfunction

  function automatic int rand_field();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 200) - 100;
    return int'($signed(16'($urandom)));
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || curve_expect_q.size() > 0 || req_ch.valid)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_regs(logic [6:0] cnt, logic sep);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= hkc_pkg::CFG_KEY_COUNT;
    cfg_data  <= cnt;
    @(posedge clk);
    cfg_index <= hkc_pkg::CFG_SEP_TAN;
    cfg_data  <= hkc_pkg::CFG_DATA_W'(sep);
    @(posedge clk);
    cfg_we    <= 1'b0;
    count_reg = cnt;
    sep_reg   = sep;
  endtask

  // Rewrite all slots, then mostly queries around the keys in use
  task automatic queue_phase(int n_eff);
    int times[NKEYS];
    int span, t, lo, hi;
    bit ordered;
    ordered = $urandom_range(0, 4) != 0;
    span = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 1000);
    t = -32768 + $urandom_range(0, 65535 - 63 * span);
    for (int k = 0; k < NKEYS; k++) begin
      times[k] = ordered ? t : int'($signed(16'($urandom)));
      t += $urandom_range(0, span);
      pending_q.push_back(key_write(k, times[k], rand_field(), rand_field(), rand_field()));
    end
    lo = times[0] - 20;
    hi = times[n_eff-1] + 20;
    if (lo > hi) begin
      t = lo; lo = hi; hi = t;
    end
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    for (int k = 0; k < 40; k++) begin
      if ($urandom_range(0, 9) == 0)
        pending_q.push_back(query_at(int'($signed(16'($urandom)))));
      else
        pending_q.push_back(query_at(lo + int'($urandom_range(0, hi - lo))));
    end
  endtask

  initial begin
    logic [6:0] cnt;
    logic       sep;
    int         n_eff;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    req_ch.valid = 1'b0;
    req_ch.func = hkc_pkg::FUNC_WRITE;
    req_ch.key_index = '0;
    req_ch.key_time = '0;
    req_ch.key_value = '0;
    req_ch.key_in_tangent = '0;
    req_ch.key_out_tangent = '0;
    req_ch.query_time = '0;
    rsp_ch.ready = 1'b0;
    calm = 1'b0;
    hold_req = 0;
    count_reg = 7'd1;
    sep_reg = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Single key in use after reset: queries see slot 0 only
    pending_q.push_back(key_write(0, 100, -7, 30, -30));
    pending_q.push_back(query_at(-32768));
    pending_q.push_back(query_at(32767));
    wait_drained();

    // Two keys spanning the whole time range with extreme values and tangents
    set_regs(7'd2, 1'b1);
    pending_q.push_back(key_write(0, -32768, 32767, 32767, -32768));
    pending_q.push_back(key_write(1, 32767, -32768, -32768, 32767));
    foreach (pending_q[k]) ;
    pending_q.push_back(query_at(-32768));
    pending_q.push_back(query_at(-32767));
    pending_q.push_back(query_at(0));
    pending_q.push_back(query_at(16384));
    pending_q.push_back(query_at(32766));
    pending_q.push_back(query_at(32767));
    // duplicate key times give a zero-length segment
    pending_q.push_back(key_write(1, -32768, 5, 0, 0));
    pending_q.push_back(query_at(-32768));
    pending_q.push_back(key_write(1, -100, 1000, -32768, -32768));
    pending_q.push_back(query_at(-32767));
    pending_q.push_back(query_at(-101));
    wait_drained();
    set_regs(7'd2, 1'b0);
    pending_q.push_back(query_at(-20000));
    pending_q.push_back(query_at(-101));
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       begin cnt = 7'd0;   sep = 1'b0; end
        1:       begin cnt = 7'd127; sep = 1'b1; end
        2:       begin cnt = 7'd64;  sep = 1'b0; end
        3:       begin cnt = 7'd1;   sep = 1'b1; end
        default: begin cnt = 7'($urandom_range(2, 64)); sep = 1'($urandom); end
      endcase
      set_regs(cnt, sep);
      n_eff = (cnt == 0) ? 1 : ((cnt > NKEYS) ? NKEYS : cnt);
      calm <= (p % 5 == 2);
      queue_phase(n_eff);
      // long receiver hold-off while the sender keeps offering
      if (p == 4) hold_req <= hold_req + 1;
      wait_drained();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d key writes and %0d queries over %0d register settings;",
             n_writes, n_queries, N_PHASES + 2);
    $display("%0d results checked, %0d of them saturated.", n_checked, n_sat);
    if (errors == 0 && curve_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
